[rtl/gau_pkg.sv]
// Package: types, constants and fixed-point helpers for the accumulator update block.
package gau_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW = $clog2(DEPTH);

  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef enum logic [3:0] {
    MODE_ADD = 4'd0, MODE_MEAN = 4'd1, MODE_DAMP = 4'd2, MODE_DAMP_SQ = 4'd3,
    MODE_DECAY = 4'd4, MODE_DECAY_SQ = 4'd5, MODE_AVG = 4'd6, MODE_AVG_SQ = 4'd7,
    MODE_INF = 4'd8
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE = 2'd0, REG_FACTOR = 2'd1, REG_MEAN_COUNT = 2'd2, REG_RESCALE = 2'd3
  } reg_idx_t;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } sat_t;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t s;
    s.clip = 1'b0;
    if (v > 66'(S32_MAX)) begin
      s.val = S32_MAX;
      s.clip = 1'b1;
    end else if (v < 66'(S32_MIN)) begin
      s.val = S32_MIN;
      s.clip = 1'b1;
    end else begin
      s.val = v[31:0];
    end
    return s;
  endfunction

  // rounded Q16.16 product from a registered 64-bit product
  function automatic sat_t qround(input logic signed [63:0] p);
    logic signed [65:0] t;
    t = (66'(p) + 66'sd32768) >>> 16;
    return sat32(t);
  endfunction

endpackage

[rtl/gau_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module gau_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/gau_div.sv]
// Restoring divider for the running-mean mode: floor(n / d), n signed 66 bits, d positive.
module gau_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [65:0] num,
  input  logic [17:0]        den,
  output logic               done,
  output logic signed [65:0] quo
);
  logic [65:0] rem_q;
  logic [65:0] q;
  logic [18:0] part;
  logic [6:0]  cnt;
  logic        busy;
  logic        neg;
  logic [65:0] mag;
  logic [18:0] trial;
  logic [18:0] part_next;
  logic [65:0] qpos;

  assign mag = num[65] ? 66'(-num) : 66'(num);
  assign trial = {part[17:0], rem_q[65]};
  assign part_next = (trial >= {1'b0, den}) ? trial - {1'b0, den} : trial;
  assign qpos = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'd0;
        rem_q <= mag;
        neg <= num[65];
        part <= '0;
        q <= '0;
      end else if (busy) begin
        part <= part_next;
        rem_q <= {rem_q[64:0], 1'b0};
        q <= {q[64:0], trial >= {1'b0, den}};
        cnt <= cnt + 7'd1;
        if (cnt == 7'd65) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // floor for negative numerators: -(q) - (rem != 0)
  assign quo = neg ? (-$signed(qpos) - ((part != '0) ? 66'sd1 : 66'sd0)) : $signed(qpos);
endmodule

[rtl/gau_mul.sv]
// Registered 32x32 signed multiplier.
module gau_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

[rtl/gradient_accumulator_update.sv]
// Gradient accumulator update: indexed Q16.16 store with optimizer update modes.
//
// Input channel (valid/stall): action, index, value. A load writes value into
// the entry; an update reads the entry, combines it with the gradient under
// the configured mode, saturates, writes back and returns the result.
// Output channel (valid/stall): out_index, new_value, saturated; one result per
// request, in order.
// Config channel (valid/ready): index selects mode, factor, mean_count,
// rescale_ratio; write only while idle.
// One request is processed at a time by a sequencer around a single RAM read
// port and one registered multiplier. States after acceptance: READ, DONE for
// a load, add or unused mode; READ, M1, M3, DONE for damp and decay; READ, M1,
// M2, DONE for infinity; READ, M1, M2, M3, DONE for damp square, decay square
// and avg; READ, M1, M2, M3, M4, DONE for avg square; READ, DIV, DONE for mean
// (one quotient bit per cycle in the divider). A new request can be taken in
// the cycle the result appears. Stall holds the result; a new request is not
// taken while that register is full and stalled. Reset empties the pipeline
// and restores register defaults; stored entries are undefined until written.
module gradient_accumulator_update (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [9:0]         index,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         out_index,
  output logic signed [31:0] new_value,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_READ = 8'b00000010, S_M1 = 8'b00000100,
    S_M2 = 8'b00001000, S_M3 = 8'b00010000, S_DIV = 8'b00100000,
    S_DONE = 8'b01000000, S_M4 = 8'b10000000
  } state_t;

  state_t state;
  logic [3:0]         mode;
  logic signed [31:0] factor;
  logic [15:0]        mean_count;
  logic signed [31:0] rescale_ratio;

  logic               act_q;
  logic [gau_pkg::AW-1:0] addr_q;
  logic signed [31:0] g_q;
  logic signed [31:0] a_q;
  logic signed [31:0] t1;
  logic signed [31:0] t2;
  logic               clip_q;
  logic signed [31:0] res;
  logic               res_clip;

  logic signed [31:0] rd;
  logic               we;
  logic signed [31:0] ma, mb;
  logic signed [63:0] mp;
  gau_pkg::sat_t      pr;
  gau_pkg::sat_t      s1, s2, s3, dq, omf, ag;

  logic               div_start, div_done;
  logic signed [65:0] div_num, div_quo;
  logic [17:0]        div_den;

  logic accept;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign we = (state == S_DONE);

  gau_ram #(.WIDTH(32), .DEPTH(gau_pkg::DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(addr_q), .wdata(res),
    .raddr(index[gau_pkg::AW-1:0]), .rdata(rd)
  );

  gau_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  gau_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  assign pr = gau_pkg::qround(mp);
  assign omf = gau_pkg::sat32(66'(gau_pkg::Q_ONE) - 66'(factor));
  assign ag = gau_pkg::sat32(g_q[31] ? -66'(g_q) : 66'(g_q));
  // rounded mean: floor((2*(a*c + g) + (c+1)) / (2*(c+1)))
  assign div_den = (18'(mean_count) + 18'd1) << 1;
  assign div_num = 66'(2) * (66'(rd) * 66'(mean_count) + 66'(g_q)) + 66'(mean_count)
                   + 66'd1;
  assign div_start = (state == S_READ) && act_q && (mode == gau_pkg::MODE_MEAN);
  assign dq = gau_pkg::sat32(div_quo);

  // multiplier operand selection per step
  always_comb begin
    ma = factor;
    mb = g_q;
    unique case (state)
      S_READ: begin
        priority case (mode)
          gau_pkg::MODE_DAMP: begin ma = factor; mb = g_q; end
          gau_pkg::MODE_DECAY: begin ma = factor; mb = rd; end
          gau_pkg::MODE_AVG, gau_pkg::MODE_AVG_SQ, gau_pkg::MODE_INF: begin
            ma = rescale_ratio; mb = factor;
          end
          default: begin ma = g_q; mb = g_q; end
        endcase
      end
      S_M1: begin
        priority case (mode)
          gau_pkg::MODE_DAMP_SQ: begin ma = factor; mb = pr.val; end
          gau_pkg::MODE_DECAY_SQ: begin ma = factor; mb = a_q; end
          default: begin ma = pr.val; mb = a_q; end
        endcase
      end
      S_M2: begin
        if (mode == gau_pkg::MODE_AVG_SQ) begin
          ma = g_q; mb = g_q;
        end else begin
          ma = omf.val; mb = g_q;
        end
      end
      S_M3: begin ma = omf.val; mb = pr.val; end
      default: begin ma = factor; mb = g_q; end
    endcase
  end

  assign s1 = gau_pkg::sat32(66'(rd) + 66'(g_q));
  assign s2 = gau_pkg::sat32(66'(t1) + 66'(t2));
  assign s3 = gau_pkg::sat32(66'(t1) + 66'(pr.val));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      mode <= 4'd0;
      factor <= gau_pkg::Q_ONE;
      mean_count <= 16'd0;
      rescale_ratio <= gau_pkg::Q_ONE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (gau_pkg::reg_idx_t'(cfg_index))
          gau_pkg::REG_MODE: mode <= cfg_data[3:0];
          gau_pkg::REG_FACTOR: factor <= cfg_data;
          gau_pkg::REG_MEAN_COUNT: mean_count <= cfg_data[15:0];
          gau_pkg::REG_RESCALE: rescale_ratio <= cfg_data;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            act_q <= action;
            addr_q <= index[gau_pkg::AW-1:0];
            g_q <= value;
            clip_q <= 1'b0;
            state <= S_READ;
          end
        end
        S_READ: begin
          a_q <= rd;
          if (act_q == gau_pkg::ACT_LOAD) begin
            res <= g_q; res_clip <= 1'b0; state <= S_DONE;
          end else begin
            priority case (mode)
              gau_pkg::MODE_ADD: begin
                res <= s1.val;
                res_clip <= s1.clip;
                state <= S_DONE;
              end
              gau_pkg::MODE_MEAN: state <= S_DIV;
              gau_pkg::MODE_DAMP, gau_pkg::MODE_DAMP_SQ, gau_pkg::MODE_DECAY,
              gau_pkg::MODE_DECAY_SQ, gau_pkg::MODE_AVG, gau_pkg::MODE_AVG_SQ,
              gau_pkg::MODE_INF: state <= S_M1;
              default: begin res <= rd; res_clip <= 1'b0; state <= S_DONE; end
            endcase
          end
        end
        S_M1: begin
          clip_q <= clip_q | pr.clip;
          priority case (mode)
            gau_pkg::MODE_DAMP: begin
              t1 <= a_q; t2 <= pr.val; state <= S_M3;
            end
            gau_pkg::MODE_DECAY: begin
              t1 <= pr.val; t2 <= g_q; state <= S_M3;
            end
            gau_pkg::MODE_DAMP_SQ: begin t1 <= a_q; state <= S_M2; end
            gau_pkg::MODE_DECAY_SQ: begin t2 <= pr.val; state <= S_M2; end
            default: state <= S_M2;
          endcase
        end
        S_M2: begin
          priority case (mode)
            gau_pkg::MODE_DAMP_SQ: begin
              t2 <= pr.val; clip_q <= clip_q | pr.clip; state <= S_M3;
            end
            gau_pkg::MODE_DECAY_SQ: begin
              t1 <= pr.val; clip_q <= clip_q | pr.clip; state <= S_M3;
            end
            gau_pkg::MODE_AVG_SQ: begin
              t1 <= pr.val; clip_q <= clip_q | pr.clip; state <= S_M3;
            end
            gau_pkg::MODE_INF: begin
              clip_q <= clip_q | pr.clip | ag.clip;
              res <= (pr.val > ag.val) ? pr.val : ag.val;
              res_clip <= clip_q | pr.clip | ag.clip;
              state <= S_DONE;
            end
            default: begin
              t1 <= pr.val; clip_q <= clip_q | pr.clip | omf.clip; state <= S_M3;
            end
          endcase
        end
        S_M3: begin
          if (mode == gau_pkg::MODE_AVG_SQ) begin
            // t1 holds lhs, product now is g*g
            clip_q <= clip_q | pr.clip | omf.clip;
            state <= S_M4;
          end else if (mode == gau_pkg::MODE_AVG) begin
            res <= s3.val;
            res_clip <= clip_q | pr.clip | s3.clip;
            state <= S_DONE;
          end else begin
            res <= s2.val; res_clip <= clip_q | s2.clip; state <= S_DONE;
          end
        end
        S_M4: begin
          res <= s3.val;
          res_clip <= clip_q | pr.clip | s3.clip;
          state <= S_DONE;
        end
        S_DIV: begin
          if (div_done) begin
            res <= dq.val;
            res_clip <= dq.clip;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_index <= 10'(addr_q);
          new_value <= res;
          saturated <= res_clip;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
